@@ rtl/tsb_pkg.sv @@
package tsb_pkg;

  // Default pool size.
  localparam int NUM_TIMERS_DEF = 8;

  // A scan reports at most this many expiries.
  localparam int MAX_RES   = 8;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  // Width of the reported slot number.
  localparam int SLOT_W = 3;

  // Operation codes.
  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_RESET = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_SCAN  = 3'd4;

  // One timer entry as it sits in the state memory.
  typedef struct packed {
    logic [7:0] count;
    logic [7:0] reload;
    logic       notify;
  } entry_t;

endpackage

@@ rtl/software_timer_bank.sv @@
// Channel   Ports                                              Beat
// in        in_valid, in_ready, in_op, in_timer_id,            one operation
//           in_start_value, in_notify
// out       out_valid, out_ready, out_slot, out_valid_res,     one result
//           out_action, out_last
//
// Allocate, tick and scan walk the state memory one slot per cycle through its
// single read port, a scan only while not stalled; allocate ends at the first
// free slot. Reset visits only the addressed slot, stop only its occupancy bit.
// Reset is synchronous; the slot occupancy bits clear at once, no memory sweep.
// A scan holds its walk while the output register is full and not taken.
module software_timer_bank #(
  parameter int NUM_TIMERS = tsb_pkg::NUM_TIMERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_op,
  input  logic [7:0]                 in_timer_id,
  input  logic [7:0]                 in_start_value,
  input  logic                       in_notify,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tsb_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_valid_res,
  output logic                       out_action,
  output logic                       out_last
);
  import tsb_pkg::*;

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  // Sequencer with slot occupancy bits and output register.
  tsb_ctrl #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_timer_id   (in_timer_id),
    .in_start_value(in_start_value),
    .in_notify     (in_notify),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_slot      (out_slot),
    .out_valid_res (out_valid_res),
    .out_action    (out_action),
    .out_last      (out_last),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata)
  );

  // Timer state memory.
  tsb_mem #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

@@ rtl/tsb_mem.sv @@
module tsb_mem #(
  parameter int NUM_TIMERS = tsb_pkg::NUM_TIMERS_DEF,
  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tsb_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output tsb_pkg::entry_t rdata
);
  import tsb_pkg::*;

  entry_t mem_r [NUM_TIMERS];
  entry_t rdata_r;

  // Single write port, single read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tsb_ctrl.sv @@
module tsb_ctrl #(
  parameter int NUM_TIMERS = tsb_pkg::NUM_TIMERS_DEF,
  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_op,
  input  logic [7:0]                 in_timer_id,
  input  logic [7:0]                 in_start_value,
  input  logic                       in_notify,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tsb_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_valid_res,
  output logic                       out_action,
  output logic                       out_last,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  tsb_pkg::entry_t            mem_rdata,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output tsb_pkg::entry_t            mem_wdata
);
  import tsb_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [7:0]            start_r, start_nxt;
  logic                  nf_r, nf_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic                  iss_done_r, iss_done_nxt;
  logic                  dv_r, dv_nxt;
  logic [AW-1:0]         idx_d_r, idx_d_nxt;
  logic [RES_CNT_W-1:0]  n_r, n_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]     pend_slot_r, pend_slot_nxt;
  logic                  pend_act_r, pend_act_nxt;
  logic [NUM_TIMERS-1:0] in_use_r, in_use_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic                  out_vres_r, out_vres_nxt;
  logic                  out_act_r, out_act_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  id_ok;
  logic [AW-1:0]         in_id;
  logic                  out_free;
  logic                  push;
  logic [SLOT_W-1:0]     push_slot;
  logic                  push_vres;
  logic                  push_act;
  logic                  push_last;
  logic                  stall;
  logic                  done_now;
  logic                  eu;

  assign id_ok    = ({1'b0, in_timer_id} < 9'(NUM_TIMERS));
  assign in_id    = in_timer_id[AW-1:0];
  assign out_free = !out_v_r || out_ready;

  // Sequencer: walks the memory one slot per cycle unless a scan stalls,
  // evaluating each slot as its data arrives, writing it back in the same cycle.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    start_nxt     = start_r;
    nf_nxt        = nf_r;
    idx_nxt       = idx_r;
    iss_done_nxt  = iss_done_r;
    dv_nxt        = dv_r;
    idx_d_nxt     = idx_d_r;
    n_nxt         = n_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_act_nxt  = pend_act_r;
    in_use_nxt    = in_use_r;
    in_ready      = (state_r == S_IDLE);
    mem_re        = 1'b0;
    mem_raddr     = idx_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_d_r;
    mem_wdata     = mem_rdata;
    push          = 1'b0;
    push_slot     = '0;
    push_vres     = 1'b0;
    push_act      = 1'b0;
    push_last     = 1'b0;
    stall         = 1'b0;
    done_now      = 1'b0;
    eu            = in_use_r[idx_d_r];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_op;
          start_nxt    = in_start_value;
          nf_nxt       = in_notify;
          idx_nxt      = '0;
          iss_done_nxt = 1'b0;
          dv_nxt       = 1'b0;
          n_nxt        = '0;
          pend_v_nxt   = 1'b0;
          case (in_op)
            OP_ALLOC, OP_TICK, OP_SCAN: begin
              state_nxt = S_RUN;
            end
            OP_RESET: begin
              if (id_ok) begin
                idx_nxt   = in_id;
                state_nxt = S_RUN;
              end
            end
            OP_STOP: begin
              // Freeing an unused slot changes nothing, so no check is needed.
              if (id_ok) begin
                in_use_nxt[in_id] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      S_RUN: begin
        // Evaluate and write back the slot whose data has arrived.
        if (dv_r) begin
          case (op_r)
            OP_ALLOC: begin
              if (!eu) begin
                mem_we               = 1'b1;
                mem_wdata.count      = start_r;
                mem_wdata.reload     = start_r;
                mem_wdata.notify     = nf_r;
                in_use_nxt[idx_d_r]  = 1'b1;
                pend_v_nxt           = 1'b1;
                pend_slot_nxt        = SLOT_W'(idx_d_r);
                pend_act_nxt         = 1'b0;
                done_now             = 1'b1;
              end
            end
            OP_TICK: begin
              if (eu && (mem_rdata.count != 8'd0)) begin
                mem_we          = 1'b1;
                mem_wdata.count = mem_rdata.count - 8'd1;
              end
            end
            OP_RESET: begin
              if (eu) begin
                mem_we          = 1'b1;
                mem_wdata.count = mem_rdata.reload;
              end
            end
            OP_SCAN: begin
              if (eu && (mem_rdata.count == 8'd0) && (n_r < RES_CNT_W'(MAX_RES))) begin
                if (pend_v_r && !out_free) begin
                  stall = 1'b1;
                end else begin
                  mem_we          = 1'b1;
                  mem_wdata.count = mem_rdata.reload;
                  // The held expiry is now known not to be the final one.
                  if (pend_v_r) begin
                    push      = 1'b1;
                    push_slot = pend_slot_r;
                    push_vres = 1'b1;
                    push_act  = pend_act_r;
                    push_last = 1'b0;
                  end
                  pend_v_nxt    = 1'b1;
                  pend_slot_nxt = SLOT_W'(idx_d_r);
                  pend_act_nxt  = mem_rdata.notify;
                  n_nxt         = n_r + RES_CNT_W'(1);
                end
              end
            end
            default: ;
          endcase
        end

        // Issue the next read, repeat the held one, or close the walk.
        if (stall) begin
          mem_re    = 1'b1;
          mem_raddr = idx_d_r;
        end else if (!iss_done_r && !done_now) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r;
          dv_nxt    = 1'b1;
          idx_d_nxt = idx_r;
          if ((idx_r == LAST_IDX) || (op_r == OP_RESET)) begin
            iss_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end else begin
          dv_nxt    = 1'b0;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // Allocate and scan close with a final beat; other ops give none.
        if ((op_r == OP_ALLOC) || (op_r == OP_SCAN)) begin
          if (out_free) begin
            push       = 1'b1;
            push_slot  = pend_v_r ? pend_slot_r : '0;
            push_vres  = pend_v_r;
            push_act   = pend_v_r ? pend_act_r : 1'b0;
            push_last  = 1'b1;
            pend_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_v_nxt    = out_v_r;
    out_slot_nxt = out_slot_r;
    out_vres_nxt = out_vres_r;
    out_act_nxt  = out_act_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_v_nxt    = 1'b1;
      out_slot_nxt = push_slot;
      out_vres_nxt = push_vres;
      out_act_nxt  = push_act;
      out_last_nxt = push_last;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      iss_done_r <= 1'b0;
      dv_r       <= 1'b0;
      n_r        <= '0;
      pend_v_r   <= 1'b0;
      in_use_r   <= '0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      iss_done_r <= iss_done_nxt;
      dv_r       <= dv_nxt;
      n_r        <= n_nxt;
      pend_v_r   <= pend_v_nxt;
      in_use_r   <= in_use_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    start_r     <= start_nxt;
    nf_r        <= nf_nxt;
    idx_r       <= idx_nxt;
    idx_d_r     <= idx_d_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_act_r  <= pend_act_nxt;
    out_slot_r  <= out_slot_nxt;
    out_vres_r  <= out_vres_nxt;
    out_act_r   <= out_act_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_slot      = out_slot_r;
  assign out_valid_res = out_vres_r;
  assign out_action    = out_act_r;
  assign out_last      = out_last_r;

endmodule

@@ rtl/tsb_checker.sv @@
module tsb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_slot,
  input logic       out_valid_res,
  input logic       out_action,
  input logic       out_last
);
  import tsb_pkg::*;

  // No result is presented right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat presented after reset");

  // An empty result carries no slot and no action.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> ((out_slot == 3'd0) && !out_action))
    else $error("empty result carries slot or action");

  // Only a found expiry can be followed by more results.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> out_valid_res)
    else $error("non-final result is not a valid expiry");

  // An allocate keeps the block busy for at least the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == OP_ALLOC)) |=> !in_ready)
    else $error("input taken while an allocate is in progress");

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_slot) &&
      $stable(out_valid_res) && $stable(out_action) && $stable(out_last)))
    else $error("stalled result beat changed");

endmodule

bind software_timer_bank tsb_checker u_tsb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_op        (in_op),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_slot     (out_slot),
  .out_valid_res(out_valid_res),
  .out_action   (out_action),
  .out_last     (out_last)
);

@@ verif/tb_software_timer_bank.sv @@
`timescale 1ns / 1ps

module tb_software_timer_bank;
  import tsb_pkg::*;

  localparam int N_TIMERS       = NUM_TIMERS_DEF;
  localparam int RANDOM_OPS     = 230;
  localparam int TAIL_ITEMS     = 40;
  localparam int LONG_HOLD      = 300;
  localparam int LONG_HOLD_AT   = 100;
  localparam int DRAIN_CYCLES   = 4 * (N_TIMERS + 3);
  localparam int WATCHDOG_LIMIT = 2000;

  // Operation codes that the block must ignore.
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] id;
    logic [7:0] start;
    logic       notify;
  } timer_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              valid_res;
    logic              action;
    logic              last;
  } timer_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_op = OP_TICK;
  logic [7:0]        in_timer_id = 8'd0;
  logic [7:0]        in_start_value = 8'd0;
  logic              in_notify = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] out_slot;
  logic              out_valid_res;
  logic              out_action;
  logic              out_last;

  software_timer_bank dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_timer_id    (in_timer_id),
    .in_start_value (in_start_value),
    .in_notify      (in_notify),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot       (out_slot),
    .out_valid_res  (out_valid_res),
    .out_action     (out_action),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  // Shadow copy of the timer pool.
  logic       tmr_busy   [N_TIMERS];
  logic [7:0] tmr_count  [N_TIMERS];
  logic [7:0] tmr_reload [N_TIMERS];
  logic       tmr_notify [N_TIMERS];

  timer_cmd_t    op_queue[$];
  timer_result_t due_results[$];

  int n_total = 0;
  int n_sent = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_allocs = 0;
  int n_pool_full = 0;
  int n_scans = 0;
  int n_expiries = 0;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < N_TIMERS; i++) begin
      tmr_busy[i] = 1'b0;
      tmr_count[i] = 8'd0;
      tmr_reload[i] = 8'd0;
      tmr_notify[i] = 1'b0;
    end
  end

  // Applies one accepted operation to the shadow pool and queues the results it causes.
  task automatic apply_timer_op(input logic [2:0] op, input logic [7:0] id,
                                input logic [7:0] start, input logic notify);
    int free_slot;
    int hits;
    int n;
    timer_result_t res;
    free_slot = -1;
    hits = 0;
    n = 0;
    case (op)
      OP_ALLOC: begin
        for (int i = N_TIMERS - 1; i >= 0; i--)
          if (!tmr_busy[i]) free_slot = i;
        res = '0;
        res.last = 1'b1;
        if (free_slot >= 0) begin
          tmr_busy[free_slot] = 1'b1;
          tmr_count[free_slot] = start;
          tmr_reload[free_slot] = start;
          tmr_notify[free_slot] = notify;
          res.slot = free_slot[SLOT_W-1:0];
          res.valid_res = 1'b1;
          n_allocs++;
        end else begin
          n_pool_full++;
        end
        due_results.push_back(res);
      end
      OP_STOP: begin
        if (id < N_TIMERS) begin
          if (tmr_busy[id]) begin
            tmr_busy[id] = 1'b0;
            tmr_notify[id] = 1'b0;
          end
        end
      end
      OP_RESET: begin
        if (id < N_TIMERS) begin
          if (tmr_busy[id]) tmr_count[id] = tmr_reload[id];
        end
      end
      OP_TICK: begin
        for (int i = 0; i < N_TIMERS; i++)
          if (tmr_busy[i] && tmr_count[i] != 8'd0) tmr_count[i] = tmr_count[i] - 8'd1;
      end
      OP_SCAN: begin
        n_scans++;
        // Count the reported expiries first so the final one can carry last.
        for (int i = 0; i < N_TIMERS; i++)
          if (tmr_busy[i] && tmr_count[i] == 8'd0 && hits < MAX_RES) hits++;
        if (hits == 0) begin
          res = '0;
          res.last = 1'b1;
          due_results.push_back(res);
        end
        for (int i = 0; i < N_TIMERS && n < hits; i++) begin
          if (tmr_busy[i] && tmr_count[i] == 8'd0) begin
            res.slot = i[SLOT_W-1:0];
            res.valid_res = 1'b1;
            res.action = tmr_notify[i];
            res.last = (n == hits - 1);
            due_results.push_back(res);
            tmr_count[i] = tmr_reload[i];
            n++;
            n_expiries++;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_op(input logic [2:0] op, input logic [7:0] id,
                        input logic [7:0] start, input logic notify);
    timer_cmd_t cmd;
    cmd.op = op;
    cmd.id = id;
    cmd.start = start;
    cmd.notify = notify;
    op_queue.push_back(cmd);
  endtask

  // Start values are mostly short so that timers expire often.
  function automatic logic [7:0] pick_start();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 8'($urandom_range(0, 4));
    if (r < 19) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  // Driver: presents queued operations, with random gaps until the last stretch.
  int  in_gap = 0;
  bit  drv_calm = 1'b0;
  timer_cmd_t next_cmd;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if ($urandom_range(0, 39) == 0) drv_calm = !drv_calm;
      if (in_valid && in_ready) begin
        apply_timer_op(in_op, in_timer_id, in_start_value, in_notify);
        n_sent++;
        if (!drv_calm && n_sent < n_total - TAIL_ITEMS && $urandom_range(0, 3) == 0)
          in_gap = $urandom_range(1, 15);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          next_cmd = op_queue.pop_front();
          in_valid <= 1'b1;
          in_op <= next_cmd.op;
          in_timer_id <= next_cmd.id;
          in_start_value <= next_cmd.start;
          in_notify <= next_cmd.notify;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Monitor: checks each result beat against the oldest expectation and drives out_ready.
  int  out_hold = 0;
  bit  long_hold_done = 1'b0;
  bit  mon_calm = 1'b0;
  timer_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (due_results.size() == 0) begin
          $error("unexpected result: slot %0d valid_res %0b action %0b last %0b",
                 out_slot, out_valid_res, out_action, out_last);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          check_field("slot", 8'(want.slot), 8'(out_slot));
          check_field("valid_res", 8'(want.valid_res), 8'(out_valid_res));
          check_field("action", 8'(want.action), 8'(out_action));
          check_field("last", 8'(want.last), 8'(out_last));
        end
      end
      if ($urandom_range(0, 39) == 0) mon_calm = !mon_calm;
      // One long hold-off lets the block fill up and stall its input.
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && n_sent >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        out_hold = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!mon_calm && n_sent < n_total - TAIL_ITEMS &&
                   $urandom_range(0, 5) == 0) begin
        out_hold = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int n_real;
    int pick;
    logic [2:0] op;
    logic [7:0] id;
    n_real = 0;

    // Directed part: empty pool, bad ids, fill to full, mass expiry, ignored ops.
    add_op(OP_SCAN, 8'd0, 8'd0, 1'b0);
    add_op(OP_STOP, 8'd0, 8'd255, 1'b1);
    add_op(OP_RESET, 8'd3, 8'd0, 1'b0);
    add_op(OP_ALLOC, 8'd255, 8'd0, 1'b1);
    add_op(OP_ALLOC, 8'd0, 8'd255, 1'b0);
    add_op(OP_ALLOC, 8'd0, 8'd1, 1'b1);
    add_op(OP_ALLOC, 8'd0, 8'd2, 1'b0);
    add_op(OP_ALLOC, 8'd0, 8'd1, 1'b1);
    add_op(OP_ALLOC, 8'd0, 8'd3, 1'b0);
    add_op(OP_ALLOC, 8'd0, 8'd0, 1'b0);
    add_op(OP_ALLOC, 8'd0, 8'd128, 1'b1);
    add_op(OP_ALLOC, 8'd0, 8'd7, 1'b1);
    add_op(OP_SCAN, 8'd0, 8'd0, 1'b0);
    add_op(OP_TICK, 8'd0, 8'd0, 1'b0);
    add_op(OP_TICK, 8'd0, 8'd0, 1'b0);
    add_op(OP_TICK, 8'd0, 8'd0, 1'b0);
    add_op(OP_SCAN, 8'd0, 8'd0, 1'b0);
    add_op(OP_STOP, 8'd255, 8'd0, 1'b0);
    add_op(OP_RESET, 8'd8, 8'd0, 1'b0);
    add_op(OP_RESET, 8'd2, 8'd0, 1'b0);
    for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++)
      add_op(c[2:0], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
    add_op(OP_STOP, 8'd1, 8'd0, 1'b0);
    add_op(OP_ALLOC, 8'd0, 8'hAA, 1'b1);
    add_op(OP_SCAN, 8'd0, 8'd0, 1'b0);

    // Random part: mostly valid ids and short counts, with some noise.
    while (n_real < RANDOM_OPS) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 6) == 0) id = 8'($urandom_range(0, 255));
      else id = 8'($urandom_range(0, N_TIMERS - 1));
      if (pick < 20) op = OP_ALLOC;
      else if (pick < 32) op = OP_STOP;
      else if (pick < 42) op = OP_RESET;
      else if (pick < 70) op = OP_TICK;
      else if (pick < 95) op = OP_SCAN;
      else op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      add_op(op, id, pick_start(), 1'($urandom_range(0, 1)));
      if (op <= OP_SCAN) n_real++;
    end
    n_total = op_queue.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while ((n_sent < n_total || due_results.size() != 0) && quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);

    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: %0d of %0d operations sent, %0d results outstanding.",
               n_sent, n_total, due_results.size());
      $display("TEST FAILED");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      $display("Ran %0d operations: %0d allocations, %0d pool-full answers, %0d scans.",
               n_total, n_allocs, n_pool_full, n_scans);
      $display("Checked %0d result beats, %0d of them expiries; %0d mismatches.",
               n_checked, n_expiries, n_errors);
      if (n_errors == 0 && due_results.size() == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
    end
    $finish;
  end

endmodule

@@ software_timer_bank.f @@
rtl/tsb_pkg.sv
rtl/tsb_mem.sv
rtl/tsb_ctrl.sv
rtl/software_timer_bank.sv
rtl/tsb_checker.sv
verif/tb_software_timer_bank.sv
